### sv/vlpsd_pkg.sv
// Shared types and codes for the length-prefixed string deframer.
package vlpsd_pkg;

   localparam int unsigned STR_LEN_W = 32;

   typedef enum logic [2:0] {
      ST_BYTE          = 3'd0,
      ST_EMPTY         = 3'd1,
      ST_TRUNC_PREFIX  = 3'd2,
      ST_LONG_PREFIX   = 3'd3,
      ST_TRUNC_PAYLOAD = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [7:0]           data_byte;
      logic [2:0]           status;
      logic                 last;
      logic [STR_LEN_W-1:0] string_length;
   } rsp_type;

endpackage

### sv/varint_length_prefixed_string_deframer.sv
// Top level of the LEB128 length-prefixed string deframer.
// Each result is registered in the result register before it appears on rsp_.
// Throughput: one byte per cycle while req_ready is high; payload bytes give one result each.
// req_ready drops only while the skid register holds a result behind a stalled rsp_ side.
// Reset (synchronous, active high) returns to prefix gathering and empties the output buffer.
module varint_length_prefixed_string_deframer #(
   parameter int unsigned LEN_BITS         = 32,
   parameter int unsigned MAX_PREFIX_BYTES = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  vlpsd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vlpsd_pkg::rsp_type rsp_data
);
   import vlpsd_pkg::*;

   logic    req_fire;
   logic    push;
   rsp_type push_data;

   // Every byte is stepped in the cycle it is accepted; the skid buffer
   // absorbs the single result that may land while the output is stalled.
   assign req_fire = req_valid && req_ready;

   vlpsd_step #(
      .LEN_BITS         (LEN_BITS),
      .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
   ) u_step (
      .clock (clock),
      .reset (reset),
      .fire  (req_fire),
      .req   (req_data),
      .push  (push),
      .rsp   (push_data)
   );

   // Output side: result register with one skid entry, so ready is registered.
   vlpsd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/vlpsd_step.sv
// Per-byte deframing state and the combinational step for one transaction.
module vlpsd_step #(
   parameter int unsigned LEN_BITS         = 32,
   parameter int unsigned MAX_PREFIX_BYTES = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  vlpsd_pkg::req_type req,
   output logic              push,
   output vlpsd_pkg::rsp_type rsp
);
   import vlpsd_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PREFIX_BYTES);

   logic                in_payload_ff, in_payload_in;
   logic [CNT_W-1:0]    prefix_count_ff, prefix_count_in;
   logic [LEN_BITS-1:0] length_accum_ff, length_accum_in;
   logic [LEN_BITS-1:0] bytes_remaining_ff, bytes_remaining_in;

   logic [LEN_BITS-1:0]           add_bits;
   logic [LEN_BITS-1:0]           accum_new;
   logic [LEN_BITS-1:0]           rem_dec;
   logic [LEN_BITS+STR_LEN_W-1:0] len_ext;
   logic                          has_rsp;

   // Place the seven new bits at 7*k for the prefix byte now arriving.
   always_comb begin
      add_bits = '0;
      for (int k = 0; k < MAX_PREFIX_BYTES; k++) begin
         if (prefix_count_ff == CNT_W'(k)) begin
            add_bits = LEN_BITS'(req.in_byte[6:0]) << (7 * k);
         end
      end
   end

   assign accum_new = length_accum_ff | add_bits;
   assign rem_dec   = bytes_remaining_ff - LEN_BITS'(1);
   assign len_ext   = {{STR_LEN_W{1'b0}}, length_accum_ff};

   always_comb begin
      in_payload_in      = in_payload_ff;
      prefix_count_in    = prefix_count_ff;
      length_accum_in    = length_accum_ff;
      bytes_remaining_in = bytes_remaining_ff;
      has_rsp            = 1'b0;
      rsp                = '0;

      if (!in_payload_ff) begin
         if (req.end_of_data) begin
            has_rsp         = 1'b1;
            rsp.status      = ST_TRUNC_PREFIX;
            prefix_count_in = '0;
            length_accum_in = '0;
         end else if (req.in_byte[7]) begin
            if (prefix_count_ff == CNT_W'(MAX_PREFIX_BYTES - 1)) begin
               has_rsp         = 1'b1;
               rsp.status      = ST_LONG_PREFIX;
               prefix_count_in = '0;
               length_accum_in = '0;
            end else begin
               prefix_count_in = prefix_count_ff + CNT_W'(1);
               length_accum_in = accum_new;
            end
         end else if (accum_new == '0) begin
            has_rsp         = 1'b1;
            rsp.status      = ST_EMPTY;
            rsp.last        = 1'b1;
            prefix_count_in = '0;
            length_accum_in = '0;
         end else begin
            in_payload_in      = 1'b1;
            prefix_count_in    = '0;
            length_accum_in    = accum_new;
            bytes_remaining_in = accum_new;
         end
      end else begin
         has_rsp           = 1'b1;
         rsp.string_length = len_ext[STR_LEN_W-1:0];
         if (req.end_of_data) begin
            rsp.status         = ST_TRUNC_PAYLOAD;
            in_payload_in      = 1'b0;
            length_accum_in    = '0;
            bytes_remaining_in = '0;
         end else begin
            rsp.status    = ST_BYTE;
            rsp.data_byte = req.in_byte;
            if (rem_dec == '0) begin
               rsp.last           = 1'b1;
               in_payload_in      = 1'b0;
               length_accum_in    = '0;
               bytes_remaining_in = '0;
            end else begin
               bytes_remaining_in = rem_dec;
            end
         end
      end
   end

   assign push = fire && has_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff      <= 1'b0;
         prefix_count_ff    <= '0;
         length_accum_ff    <= '0;
         bytes_remaining_ff <= '0;
      end else if (fire) begin
         in_payload_ff      <= in_payload_in;
         prefix_count_ff    <= prefix_count_in;
         length_accum_ff    <= length_accum_in;
         bytes_remaining_ff <= bytes_remaining_in;
      end
   end

   // payload phase always has at least one byte left to pass
   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> bytes_remaining_ff != '0)
      else $error("payload phase with zero bytes remaining");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      prefix_count_ff <= CNT_W'(MAX_PREFIX_BYTES - 1))
      else $error("prefix byte count out of range");

   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> prefix_count_ff == '0)
      else $error("prefix count not cleared in payload phase");

   a_len_match: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> bytes_remaining_ff <= length_accum_ff)
      else $error("remaining count exceeds string length");

endmodule

### sv/vlpsd_skid.sv
// Two-entry output buffer: result register plus skid register.
module vlpsd_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vlpsd_pkg::rsp_type push_data,
   output logic               in_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vlpsd_pkg::rsp_type rsp_data
);
   import vlpsd_pkg::*;

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_data_ff, skid_data_ff;

   assign in_ready  = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !main_valid_ff) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   a_skid_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a result in front");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed into a full buffer");

endmodule

### tb/sv/tb_vlpsd_scoreboard_pkg.sv
// Scoreboard class: deframer prediction and result checking.
`timescale 1ns / 1ps

package tb_vlpsd_scoreboard_pkg;
   import vlpsd_pkg::*;

   class deframer_scoreboard;
      localparam int unsigned LEN_BITS   = 32;
      localparam int unsigned MAX_PREFIX = 5;

      bit          in_payload;
      int unsigned prefix_count;
      bit [31:0]   length_accum;
      bit [31:0]   bytes_remaining;
      rsp_type     deframed_queue[$];
      int unsigned mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         in_payload      = 1'b0;
         prefix_count    = 0;
         length_accum    = '0;
         bytes_remaining = '0;
      endfunction

      // One stream byte in, at most one deframed result out.
      function bit deframe_byte(input req_type item, output rsp_type frame);
         bit [63:0]   chunk;
         int unsigned shift;
         frame = '0;
         if (!in_payload) begin
            if (item.end_of_data) begin
               restart();
               frame.status = ST_TRUNC_PREFIX;
               return 1'b1;
            end
            shift = 7 * prefix_count;
            if (shift < LEN_BITS) begin
               chunk = 64'(item.in_byte[6:0]) << shift;
               length_accum = length_accum | chunk[31:0];
            end
            prefix_count++;
            if (item.in_byte[7]) begin
               if (prefix_count >= MAX_PREFIX) begin
                  restart();
                  frame.status = ST_LONG_PREFIX;
                  return 1'b1;
               end
               return 1'b0;
            end
            if (length_accum == 0) begin
               restart();
               frame.status = ST_EMPTY;
               frame.last   = 1'b1;
               return 1'b1;
            end
            in_payload      = 1'b1;
            prefix_count    = 0;
            bytes_remaining = length_accum;
            return 1'b0;
         end
         frame.string_length = length_accum;
         if (item.end_of_data) begin
            frame.status = ST_TRUNC_PAYLOAD;
            restart();
            return 1'b1;
         end
         frame.data_byte = item.in_byte;
         frame.status    = ST_BYTE;
         bytes_remaining = bytes_remaining - 1;
         if (bytes_remaining == 0) begin
            frame.last = 1'b1;
            restart();
         end
         return 1'b1;
      endfunction

      function void note_request(input req_type item);
         rsp_type frame;
         if (deframe_byte(item, frame))
            deframed_queue.push_back(frame);
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (deframed_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: byte %02h status %0d last %0b len %0d",
                        got.data_byte, got.status, got.last, got.string_length);
            return;
         end
         want = deframed_queue.pop_front();
         if (got.data_byte !== want.data_byte || got.status !== want.status ||
             got.last !== want.last || got.string_length !== want.string_length) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected byte %02h status %0d last %0b len %0d, %s",
                        want.data_byte, want.status, want.last, want.string_length,
                        $sformatf("got byte %02h status %0d last %0b len %0d",
                                  got.data_byte, got.status, got.last,
                                  got.string_length));
         end
      endfunction

      function int unsigned pending();
         return deframed_queue.size();
      endfunction
   endclass

endpackage

### tb/sv/tb_varint_length_prefixed_string_deframer.sv
// Testbench top: random and directed byte streams through the string deframer.
`timescale 1ns / 1ps

module tb_varint_length_prefixed_string_deframer;
   import vlpsd_pkg::*;
   import tb_vlpsd_scoreboard_pkg::*;

   // cycles without any transaction before the run is declared hung
   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned PHASE_ITEMS = 270;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   deframer_scoreboard board = new();

   // idle percentages per phase, read by the sender task and the receiver process
   int unsigned send_idle_pct = 11;
   int unsigned recv_idle_pct = 65;
   // main process posts a hold-off length, receiver process counts it down
   int unsigned hold_request  = 0;
   int unsigned items_sent    = 0;

   always #1 clock = ~clock;

   varint_length_prefixed_string_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Offer one stream byte (or end-of-data marker) and wait for the transaction.
   // Valid is only lowered for a random idle gap, never between back-to-back items.
   task automatic offer(input logic [7:0] b, input bit eod);
      req_type item;
      item.in_byte     = b;
      item.end_of_data = eod;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
      items_sent++;
   endtask

   task automatic send_eod();
      offer(8'($urandom), 1'b1);
   endtask

   // LEB128 prefix in nbytes bytes; padding uses zero-valued continuation bytes.
   // On the fifth byte the upper bits land beyond 32 bits and must be dropped.
   task automatic send_prefix(input bit [31:0] len, input int unsigned nbytes);
      bit [63:0]  wide;
      logic [7:0] pb;
      wide = 64'(len);
      for (int unsigned i = 0; i < nbytes; i++) begin
         pb = {1'b0, 7'(wide >> (7 * i))};
         if (i == 4)
            pb[6:4] = 3'($urandom);
         if (i < nbytes - 1)
            pb[7] = 1'b1;
         offer(pb, 1'b0);
      end
   endtask

   function automatic int unsigned min_prefix_bytes(input bit [31:0] len);
      int unsigned n;
      n = 1;
      while (n < 5 && (64'(len) >> (7 * n)) != 0)
         n++;
      return n;
   endfunction

   // Full frame: prefix, then sent payload bytes; end-of-data if cut short.
   task automatic send_string(input bit [31:0] len, input int unsigned nbytes,
                              input int unsigned sent);
      logic [7:0] pay;
      send_prefix(len, nbytes);
      if (len == 0)
         return;
      if (sent > len)
         sent = len;
      for (int unsigned i = 0; i < sent; i++) begin
         case ($urandom_range(7))
            0: pay = 8'h00;
            1: pay = 8'hFF;
            default: pay = 8'($urandom);
         endcase
         offer(pay, 1'b0);
      end
      if (sent < len)
         send_eod();
   endtask

   // One randomly chosen frame; mostly well formed, the rest broken or noise.
   task automatic send_random_frame();
      int unsigned kind;
      int unsigned k;
      bit [31:0]   len;
      kind = $urandom_range(99);
      if (kind < 60) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(300, 128) : $urandom_range(12);
         k   = min_prefix_bytes(len);
         if ($urandom_range(7) == 0)
            k = $urandom_range(5, k);
         send_string(len, k, len);
      end else if (kind < 72) begin
         len = $urandom_range(20, 1);
         send_string(len, min_prefix_bytes(len), $urandom_range(len - 1));
      end else if (kind < 80) begin
         // huge length: only a few bytes, then the source runs dry
         len = $urandom;
         k   = ($urandom_range(1) == 0) ? 5 : min_prefix_bytes(len);
         send_string(len, k, $urandom_range(6));
      end else if (kind < 87) begin
         k = $urandom_range(4);
         for (int unsigned i = 0; i < k; i++)
            offer(8'($urandom) | 8'h80, 1'b0);
         send_eod();
      end else if (kind < 93) begin
         for (int unsigned i = 0; i < 5; i++)
            offer(8'($urandom) | 8'h80, 1'b0);
      end else begin
         send_eod();
      end
   endtask

   // always lets at least one edge pass, so valid is never driven twice in one step
   task automatic wait_drained();
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Receiver: checks each accepted result, then picks ready for the next cycle.
   // A posted hold-off keeps ready low long enough for the block to stall its input.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_response(rsp_data);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: any transaction on either side clears the count.
   initial begin
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("tb_varint_length_prefixed_string_deframer NOT OK");
      $finish;
   end

   initial begin
      int unsigned phase_end;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed frames
      send_eod();                                      // end of data before any prefix
      offer(8'h00, 1'b0);                              // empty string
      offer(8'h01, 1'b0); offer(8'h00, 1'b0);          // zero byte passed as payload
      offer(8'h02, 1'b0); offer(8'hFF, 1'b0); offer(8'hAA, 1'b0);
      for (int unsigned i = 0; i < 5; i++)             // prefix too long
         offer(8'h80, 1'b0);
      offer(8'h81, 1'b0); send_eod();                  // cut inside the prefix
      offer(8'h03, 1'b0); offer(8'h55, 1'b0); send_eod();  // cut inside the payload
      offer(8'h80, 1'b0); offer(8'h00, 1'b0);          // padded zero length
      // fifth byte bits fall above 32 bits: length wraps to zero, empty string
      for (int unsigned i = 0; i < 4; i++)
         offer(8'h80, 1'b0);
      offer(8'h70, 1'b0);
      // all-ones length, cut short
      send_string(32'hFFFF_FFFF, 5, 2);
      req_valid <= 1'b0;
      wait_drained();

      // Three idling phases: sender-light, receiver-light, then none.
      for (int unsigned phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 11; recv_idle_pct = 65; end
            1: begin send_idle_pct = 65; recv_idle_pct = 11; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         // long receiver hold-off while a long string keeps the input busy
         hold_request = 50;
         send_string(30, 1, 30);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end)
            send_random_frame();
         // sender pauses until everything predicted has come back
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (board.pending() != 0)
         $display("%0d results never arrived", board.pending());
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb_varint_length_prefixed_string_deframer OK");
      else
         $display("tb_varint_length_prefixed_string_deframer NOT OK");
      $finish;
   end

endmodule

### varint_length_prefixed_string_deframer.f
sv/vlpsd_pkg.sv
sv/vlpsd_step.sv
sv/vlpsd_skid.sv
sv/varint_length_prefixed_string_deframer.sv
tb/sv/tb_vlpsd_scoreboard_pkg.sv
tb/sv/tb_varint_length_prefixed_string_deframer.sv
